[hdl/vccm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the vector clock compare-and-merge block.
// No dependencies; imported by every module of the block.
package vccm_pkg;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ELEM = 1'b1;

   localparam logic [1:0] REL_LOCAL_NEWER = 2'd0;
   localparam logic [1:0] REL_INCOMING    = 2'd1;
   localparam logic [1:0] REL_CONCURRENT  = 2'd2;

   localparam logic REG_OWN_SLOT = 1'b0;
   localparam logic REG_OWN_RANK = 1'b1;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int FIFO_AW        = $clog2(RSP_FIFO_DEPTH);
   localparam int FIFO_CW        = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic       may_enter;
      logic [1:0] relation;
   } result_type;

endpackage

[hdl/vccm_rsp_fifo.sv]
`timescale 1ns / 1ps
// Small result queue that decouples the merge pipeline from the response channel.
// Depends on vccm_pkg for the result type and the queue depth.
module vccm_rsp_fifo import vccm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  result_type         push_data,
   input  logic               out_ready,
   output logic               out_valid,
   output result_type         out_data,
   output logic [FIFO_CW-1:0] count
);

   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   result_type         entry_ff [RSP_FIFO_DEPTH];
   logic               pop;

   assign pop       = out_ready && (count_ff != '0);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + FIFO_CW'(1);
         2'b01:   count_in = count_ff - FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < FIFO_CW'(RSP_FIFO_DEPTH)))
      else $error("result queue written while full");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + FIFO_CW'(1)))
      else $error("result queue count did not advance on push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - FIFO_CW'(1)))
      else $error("result queue count did not drop on pop");

endmodule

[hdl/vector_clock_compare_merge.sv]
`timescale 1ns / 1ps
// Result path: the last element is registered in stage 1, its result enters the rsp queue.
// Throughput: one req transaction per cycle while req_tready shows queue room, set by the
// single read and write port of the counter memory; same-entry overlap uses a write bypass.
// Reset: synchronous; per-entry valid bits make every counter read as zero at once,
// so no clearing pass is needed and the block accepts transactions right after reset.
module vector_clock_compare_merge import vccm_pkg::*; #(
   parameter int NUM_PROCS   = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] elem_value, [19:16] sender_id, rest zero
   input  logic        req_tlast,
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] relation, [2] may_enter, rest zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(NUM_PROCS);
   localparam int SW = $clog2(NUM_PROCS + 1);
   localparam int OW = (AW > 4) ? AW : 4;
   localparam int VW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [3:0]             own_slot_ff, own_rank_ff;
   logic                   csr_wr;

   logic                   req_fire, is_elem, slot_ok, tick_ok, in_range;
   logic [15:0]            elem_value;
   logic [3:0]             sender_id;
   logic [OW-1:0]          own_ext;
   logic [AW-1:0]          rd_addr;
   logic [VW-1:0]          val_ext;
   logic [COUNT_WIDTH-1:0] val_sat;
   logic [SW-1:0]          slot_ff, slot_in;

   logic                   s1_valid_ff, s1_is_elem_ff, s1_last_ff, s1_in_range_ff;
   logic [AW-1:0]          s1_addr_ff;
   logic [COUNT_WIDTH-1:0] s1_value_ff;
   logic [3:0]             s1_sender_ff;

   logic [COUNT_WIDTH-1:0] mem [NUM_PROCS];
   logic [NUM_PROCS-1:0]   mem_valid_ff;
   logic [COUNT_WIDTH-1:0] mem_rdata_ff;
   logic                   rd_valid_ff;
   logic                   byp_valid_ff;
   logic [AW-1:0]          byp_addr_ff;
   logic [COUNT_WIDTH-1:0] byp_data_ff;

   logic [COUNT_WIDTH-1:0] mine, mem_wdata;
   logic                   mem_we, smaller, larger, all_smaller, all_larger;
   logic                   seen_smaller_ff, seen_smaller_in;
   logic                   seen_larger_ff, seen_larger_in;
   logic                   push;
   result_type             result, fifo_data;
   logic [FIFO_CW-1:0]     fifo_count, pending;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = {28'b0, (csr_paddr[2] == REG_OWN_RANK) ? own_rank_ff : own_slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         own_slot_ff <= '0;
         own_rank_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_OWN_SLOT: own_slot_ff <= csr_pwdata[3:0];
            REG_OWN_RANK: own_rank_ff <= csr_pwdata[3:0];
            default:      own_slot_ff <= own_slot_ff;
         endcase
      end
   end

   assign pending    = fifo_count + FIFO_CW'(push);
   assign req_tready = (pending <= FIFO_CW'(RSP_FIFO_DEPTH - 2));
   assign req_fire   = req_tvalid && req_tready;

   assign elem_value = req_tdata[15:0];
   assign sender_id  = req_tdata[19:16];
   assign is_elem    = (req_tuser == REQ_ELEM);
   assign own_ext    = OW'(own_slot_ff);
   assign tick_ok    = ({28'b0, own_slot_ff} < 32'(NUM_PROCS));
   assign slot_ok    = (slot_ff < SW'(NUM_PROCS));
   assign rd_addr    = is_elem ? slot_ff[AW-1:0] : own_ext[AW-1:0];
   assign in_range   = is_elem ? slot_ok : tick_ok;
   assign val_ext    = VW'(elem_value);
   assign val_sat    = (val_ext > VW'(COUNT_MAX)) ? COUNT_MAX : val_ext[COUNT_WIDTH-1:0];

   always_comb begin
      slot_in = slot_ff;
      if (req_fire && is_elem) begin
         if (req_tlast) begin
            slot_in = '0;
         end else if (slot_ok) begin
            slot_in = slot_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         slot_ff     <= slot_in;
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_is_elem_ff  <= is_elem;
         s1_last_ff     <= req_tlast;
         s1_in_range_ff <= in_range;
         s1_addr_ff     <= rd_addr;
         s1_value_ff    <= val_sat;
         s1_sender_ff   <= sender_id;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_addr_ff] <= mem_wdata;
      end
      if (req_fire) begin
         mem_rdata_ff <= mem[rd_addr];
         rd_valid_ff  <= mem_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         byp_valid_ff <= mem_we;
         if (mem_we) begin
            mem_valid_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byp_addr_ff <= s1_addr_ff;
         byp_data_ff <= mem_wdata;
      end
   end

   always_comb begin
      if (byp_valid_ff && (byp_addr_ff == s1_addr_ff)) begin
         mine = byp_data_ff;
      end else if (rd_valid_ff) begin
         mine = mem_rdata_ff;
      end else begin
         mine = '0;
      end
      smaller = (mine < s1_value_ff);
      larger  = (mine > s1_value_ff);
      if (s1_is_elem_ff) begin
         mem_wdata = smaller ? s1_value_ff : mine;
      end else begin
         mem_wdata = (mine != COUNT_MAX) ? mine + COUNT_WIDTH'(1) : mine;
      end
   end

   assign mem_we      = s1_valid_ff && s1_in_range_ff;
   assign all_smaller = seen_smaller_ff || (s1_in_range_ff && smaller);
   assign all_larger  = seen_larger_ff || (s1_in_range_ff && larger);
   assign push        = s1_valid_ff && s1_is_elem_ff && s1_last_ff;

   always_comb begin
      seen_smaller_in = seen_smaller_ff;
      seen_larger_in  = seen_larger_ff;
      if (s1_valid_ff && s1_is_elem_ff) begin
         seen_smaller_in = s1_last_ff ? 1'b0 : all_smaller;
         seen_larger_in  = s1_last_ff ? 1'b0 : all_larger;
      end
      if (all_larger && !all_smaller) begin
         result.relation = REL_LOCAL_NEWER;
      end else if (all_larger && all_smaller) begin
         result.relation = REL_CONCURRENT;
      end else begin
         result.relation = REL_INCOMING;
      end
      result.may_enter = (result.relation == REL_LOCAL_NEWER) ||
                         ((result.relation == REL_CONCURRENT) && (own_rank_ff > s1_sender_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_smaller_ff <= 1'b0;
         seen_larger_ff  <= 1'b0;
      end else begin
         seen_smaller_ff <= seen_smaller_in;
         seen_larger_ff  <= seen_larger_in;
      end
   end

   vccm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (fifo_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = {5'b0, fifo_data};

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SW'(NUM_PROCS))
      else $error("slot counter ran past the number of processes");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_elem && req_tlast) |=> (slot_ff == '0) && s1_valid_ff)
      else $error("last element did not restart the slot counter");

   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("finished message produced no response");

   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> !seen_smaller_ff && !seen_larger_ff)
      else $error("comparison flags survived the end of a message");

endmodule

[test/vector_clock_compare_merge_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for vector_clock_compare_merge: stream in, stream out, APB registers.
// Depends on vccm_pkg and the block; expected orderings come from an in-bench clock predictor.
module vector_clock_compare_merge_tb import vccm_pkg::*; ();

   localparam int NUM_PROCS   = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;   // [15:0] elem_value, [19:16] sender_id, rest zero
   logic        req_tlast   = 1'b0;
   logic        req_tuser   = REQ_TICK;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;   // [1:0] relation, [2] may_enter, rest zero
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   vector_clock_compare_merge #(
      .NUM_PROCS   (NUM_PROCS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [COUNT_WIDTH-1:0] merged_clock [NUM_PROCS];
   int                     next_slot;
   bit                     local_smaller;
   bit                     local_larger;
   logic [3:0]             own_slot_q;
   logic [3:0]             own_rank_q;
   result_type             pending_results [$];

   int  error_count    = 0;
   int  items_sent     = 0;
   int  results_seen   = 0;
   int  config_writes  = 0;
   int  cycle_count    = 0;
   int  relation_count [4] = '{0, 0, 0, 0};
   bit  sender_gaps_on = 1'b1;
   bit  rx_gaps_on     = 1'b1;
   int  hold_request   = 0;
   int  hold_left      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!rx_gaps_on) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 38);
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 20)
         $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, relation", rsp_tdata[1:0], -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.relation)
               report_mismatch("relation", rsp_tdata[1:0], want.relation);
            if (rsp_tdata[2] !== want.may_enter)
               report_mismatch("may_enter", rsp_tdata[2], want.may_enter);
            relation_count[want.relation]++;
         end
      end
   end

   function automatic void clear_clock_state();
      foreach (merged_clock[i]) merged_clock[i] = '0;
      next_slot = 0;
      local_smaller = 1'b0;
      local_larger = 1'b0;
      own_slot_q = '0;
      own_rank_q = '0;
   endfunction

   function automatic void track_transaction(input logic kind, input logic [15:0] value,
                                             input logic last, input logic [3:0] sender);
      int         theirs;
      result_type res;
      if (kind == REQ_TICK) begin
         if (own_slot_q < NUM_PROCS && merged_clock[own_slot_q] < COUNT_MAX)
            merged_clock[own_slot_q] = merged_clock[own_slot_q] + 1'b1;
         return;
      end
      theirs = (value > COUNT_MAX) ? COUNT_MAX : value;
      if (next_slot < NUM_PROCS) begin
         if (merged_clock[next_slot] < theirs) begin
            local_smaller = 1'b1;
            merged_clock[next_slot] = theirs[COUNT_WIDTH-1:0];
         end else if (merged_clock[next_slot] > theirs) begin
            local_larger = 1'b1;
         end
         next_slot++;
      end
      if (!last) return;
      if (local_larger && !local_smaller)
         res.relation = REL_LOCAL_NEWER;
      else if (local_larger && local_smaller)
         res.relation = REL_CONCURRENT;
      else
         res.relation = REL_INCOMING;
      if (res.relation == REL_LOCAL_NEWER)
         res.may_enter = 1'b1;
      else if (res.relation == REL_CONCURRENT)
         res.may_enter = (own_rank_q > sender);
      else
         res.may_enter = 1'b0;
      pending_results.push_back(res);
      next_slot = 0;
      local_smaller = 1'b0;
      local_larger = 1'b0;
   endfunction

   task automatic send_item(input logic kind, input logic [15:0] value, input logic last,
                            input logic [3:0] sender);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= last;
      req_tdata  <= {4'b0000, sender, value};
      do @(posedge clock); while (!req_tready);
      track_transaction(kind, value, last, sender);
      items_sent++;
      if (sender_gaps_on) begin
         gap = 0;
         while ($urandom_range(99) < 38) gap++;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_tick();
      send_item(REQ_TICK, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                4'($urandom_range(15)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [3:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {28'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_OWN_SLOT)
         own_slot_q = value;
      else
         own_rank_q = value;
      config_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // The mode steers each element around the local counter: 0 either side,
   // 1 at or above it, 2 at or below it.
   function automatic logic [15:0] pick_value(input int slot, input int mode);
      int r;
      int v;
      r = $urandom_range(99);
      if (slot >= NUM_PROCS || r < 8) return 16'($urandom_range(16'hFFFF));
      if (r < 18) return '0;
      if (r < 20) return 16'(COUNT_MAX);
      case (mode)
         1: v = int'(merged_clock[slot]) + int'($urandom_range(3));
         2: v = int'(merged_clock[slot]) - int'($urandom_range(3));
         default: v = int'(merged_clock[slot]) + int'($urandom_range(6)) - 3;
      endcase
      if (v < 0) v = 0;
      if (v > COUNT_MAX) v = COUNT_MAX;
      return v[15:0];
   endfunction

   task automatic send_message(input int len);
      int mode;
      mode = $urandom_range(2);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 12) send_tick();
         send_item(REQ_ELEM, pick_value(i, mode), (i == len - 1), 4'($urandom_range(15)));
      end
   endtask

   task automatic test_tick_and_saturation();
      send_item(REQ_TICK, 16'h0000, 1'b0, 4'd0);
      send_item(REQ_ELEM, 16'h0000, 1'b1, 4'd15);
      send_item(REQ_ELEM, 16'hFFFF, 1'b1, 4'd0);
      send_item(REQ_TICK, 16'hFFFF, 1'b1, 4'd15);
      send_item(REQ_ELEM, 16'hFFFF, 1'b0, 4'd15);
      send_item(REQ_ELEM, 16'h0000, 1'b1, 4'd0);
   endtask

   task automatic test_relations();
      wait_idle();
      write_csr(REG_OWN_RANK, 4'd15);
      send_item(REQ_ELEM, 16'h0000, 1'b0, 4'd3);
      send_item(REQ_ELEM, 16'h0005, 1'b1, 4'd0);
      send_item(REQ_ELEM, 16'h0000, 1'b0, 4'd0);
      send_item(REQ_ELEM, 16'h0006, 1'b1, 4'd15);
      wait_idle();
      write_csr(REG_OWN_RANK, 4'd0);
      send_item(REQ_ELEM, 16'h0000, 1'b0, 4'd9);
      send_item(REQ_ELEM, 16'h0007, 1'b1, 4'd0);
   endtask

   task automatic test_message_shapes();
      wait_idle();
      write_csr(REG_OWN_SLOT, 4'd15);
      send_item(REQ_ELEM, 16'h0000, 1'b0, 4'd6);
      send_item(REQ_TICK, 16'h1234, 1'b0, 4'd2);
      send_item(REQ_ELEM, 16'h0009, 1'b1, 4'd1);
      for (int i = 0; i < NUM_PROCS + 2; i++)
         send_item(REQ_ELEM, (i < NUM_PROCS) ? 16'hFFFF : 16'h0000, (i == NUM_PROCS + 1),
                   4'd9);
   endtask

   task automatic run_traffic(input int count, input bit gaps);
      int goal;
      int r;
      goal = items_sent + count;
      sender_gaps_on = gaps;
      rx_gaps_on = gaps;
      while (items_sent < goal) begin
         r = $urandom_range(99);
         if (r < 70)
            send_message($urandom_range(1, NUM_PROCS));
         else if (r < 80)
            send_message($urandom_range(NUM_PROCS + 1, NUM_PROCS + 4));
         else if (r < 99)
            send_tick();
         else
            wait_idle();
      end
   endtask

   task automatic test_random_traffic();
      logic [3:0] slots [4] = '{4'd0, 4'd15, 4'd0, 4'd15};
      logic [3:0] ranks [4] = '{4'd15, 4'd0, 4'd0, 4'd15};
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_csr(REG_OWN_SLOT, (p == 2) ? 4'($urandom_range(15)) : slots[p]);
         write_csr(REG_OWN_RANK, (p == 2) ? 4'($urandom_range(15)) : ranks[p]);
         run_traffic(350, p != 1);
      end
      sender_gaps_on = 1'b1;
      rx_gaps_on = 1'b1;
   endtask

   task automatic test_backpressure();
      wait_idle();
      sender_gaps_on = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 30; i++)
         send_item(REQ_ELEM, 16'($urandom_range(16'hFFFF)), 1'b1, 4'($urandom_range(15)));
      sender_gaps_on = 1'b1;
      wait_idle();
   endtask

   initial begin
      clear_clock_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_tick_and_saturation();
      test_relations();
      test_message_shapes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      $display("Run covered %0d transactions in, %0d results out, %0d register writes.",
               items_sent, results_seen, config_writes);
      $display("Orderings: %0d local newer, %0d incoming newer or equal, %0d concurrent.",
               relation_count[REL_LOCAL_NEWER], relation_count[REL_INCOMING],
               relation_count[REL_CONCURRENT]);
      if (error_count == 0 && pending_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
